>>> rtl/tpu_pkg.sv
package tpu_pkg;

	// Field widths of the pattern stream and of the unpacked cells.
	localparam int BYTE_W    = 8;
	localparam int ROW_W     = 9;
	localparam int ROW_OUT_W = 8;
	localparam int CHAN_OUT_W = 5;
	localparam int CC_W      = 6;
	localparam int CLAMP_W   = 7;
	localparam int FIELDS    = 5;

	// Header byte decoding.
	localparam int MASK_FLAG_BIT = 7;
	localparam logic [FIELDS-1:0] FIELD_NOTE  = 5'h01;
	localparam logic [FIELDS-1:0] FIELD_INSTR = 5'h02;
	localparam logic [FIELDS-1:0] FIELD_VOL   = 5'h04;
	localparam logic [FIELDS-1:0] FIELD_EFF   = 5'h08;
	localparam logic [FIELDS-1:0] FIELD_PARAM = 5'h10;
	localparam logic [FIELDS-1:0] FULL_CELL_REST =
		FIELD_INSTR | FIELD_VOL | FIELD_EFF | FIELD_PARAM;

	// Smallest channel count that the unpacker honors.
	localparam int MIN_CHANNELS = 2;

	// Register map and reset values.
	localparam logic REG_CHANNEL_COUNT = 1'b0;
	localparam logic REG_ROW_COUNT     = 1'b1;
	localparam logic [CC_W-1:0]  CHANNEL_COUNT_RST = 6'd2;
	localparam logic [ROW_W-1:0] ROW_COUNT_RST     = 9'd64;

	// Queue between the byte decoder and the result port.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	typedef struct packed {
		logic [BYTE_W-1:0] packed_byte;
		logic              end_of_data;
	} in_item_t;

	typedef struct packed {
		logic [ROW_OUT_W-1:0]  row_index;
		logic [CHAN_OUT_W-1:0] channel_index;
		logic [BYTE_W-1:0]     note_value;
		logic [BYTE_W-1:0]     instrument_value;
		logic [BYTE_W-1:0]     volume_value;
		logic [BYTE_W-1:0]     effect_value;
		logic [BYTE_W-1:0]     param_value;
		logic                  last_cell;
	} out_item_t;

	typedef struct packed {
		logic [CC_W-1:0]  channel_count;
		logic [ROW_W-1:0] row_count;
	} cfg_t;

	// Handshake from the decoder into the queue.
	typedef struct packed {
		logic      push;
		out_item_t data;
	} cell_push_t;

endpackage

>>> rtl/tracker_pattern_unpacker.sv
// Unpacks a tracker pattern stream one byte per clock unless the result queue is full. A header
// byte with bit 7 set names which of the five cell fields follow; a byte with bit 7 clear opens
// a full five-byte cell. Each finished cell enters the queue with its row and channel as its
// last byte is accepted, and last_cell marks the end of the pattern or of the data. The sustained
// rate is one byte per cycle unless the queue is full: a two-entry queue ahead of the output
// lets the input keep flowing while a result waits to be taken. Bytes past the configured row
// count are dropped; an end-of-data byte always returns the unpacker to row 0, channel 0. The
// channel and row counts are written through the register port at byte addresses 0 and 4; the
// user must write them only while the block is idle, which it does not enforce.
module tracker_pattern_unpacker import tpu_pkg::*; #(
	parameter int MAX_CHANNELS = 32,
	parameter int MAX_ROWS     = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t       cfg_q;
	logic       reg_sel;
	logic       wr_en;
	logic       q_full;
	cell_push_t cell_push;

	// Register port.
	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_count <= CHANNEL_COUNT_RST;
			cfg_q.row_count     <= ROW_COUNT_RST;
		end else if (wr_en) begin
			case (reg_sel)
				REG_CHANNEL_COUNT: cfg_q.channel_count <= pwdata[CC_W-1:0];
				REG_ROW_COUNT:     cfg_q.row_count     <= pwdata[ROW_W-1:0];
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	// Read back.
	always_comb begin
		case (reg_sel)
			REG_CHANNEL_COUNT: prdata = 32'(cfg_q.channel_count);
			REG_ROW_COUNT:     prdata = 32'(cfg_q.row_count);
			default:           prdata = '0;
		endcase
	end

	// Byte decoder and cell assembly.
	tpu_front #(
		.MAX_CHANNELS(MAX_CHANNELS),
		.MAX_ROWS    (MAX_ROWS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.cell_push(cell_push)
	);

	// Result queue and output port.
	tpu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.cell_push(cell_push),
		.full     (q_full),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

>>> rtl/tpu_front.sv
module tpu_front import tpu_pkg::*; #(
	parameter int MAX_CHANNELS = 32,
	parameter int MAX_ROWS     = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_data,
	input  cfg_t       cfg,
	input  logic       q_full,
	output cell_push_t cell_push
);

	localparam int CHAN_W = (MAX_CHANNELS > 2) ? $clog2(MAX_CHANNELS) : 1;

	logic [FIELDS-1:0]             pending_q;
	logic [FIELDS-1:0][BYTE_W-1:0] cell_q;
	logic [CHAN_W-1:0]             chan_q;
	logic [ROW_W-1:0]              row_q;
	logic                          done_q;

	logic                          accept;
	logic                          blocked;
	logic [CLAMP_W-1:0]            cc_ext;
	logic [CLAMP_W-1:0]            chans;
	logic [ROW_W-1:0]              rows;
	logic [FIELDS-1:0]             sel;
	logic [FIELDS-1:0]             pend_n;
	logic [FIELDS-1:0][BYTE_W-1:0] fields_n;
	logic                          emit;
	logic                          wrap;
	logic [CHAN_W-1:0]             chan_adv;
	logic [ROW_W-1:0]              row_adv;
	logic                          done_n;

	// The queue in front of the result port sets the pace.
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Clamp the configured geometry to what the counters support.
	assign cc_ext = CLAMP_W'(cfg.channel_count);
	always_comb begin
		if (cc_ext < CLAMP_W'(MIN_CHANNELS)) begin
			chans = CLAMP_W'(MIN_CHANNELS);
		end else if (cc_ext > CLAMP_W'(MAX_CHANNELS)) begin
			chans = CLAMP_W'(MAX_CHANNELS);
		end else begin
			chans = cc_ext;
		end
	end
	assign rows = (cfg.row_count > ROW_W'(MAX_ROWS)) ? ROW_W'(MAX_ROWS) : cfg.row_count;

	// Bytes past the last row are dropped.
	assign blocked = done_q || (row_q >= rows);

	// With nothing pending a byte opens a cell (mask or note); otherwise it fills the lowest pending field.
	assign sel = pending_q & (~pending_q + FIELDS'(1));
	always_comb begin
		fields_n = cell_q;
		pend_n   = pending_q & ~sel;
		if (pending_q == '0) begin
			fields_n = '0;
			if (in_data.packed_byte[MASK_FLAG_BIT]) begin
				pend_n = in_data.packed_byte[FIELDS-1:0];
			end else begin
				fields_n[0] = in_data.packed_byte;
				pend_n      = FULL_CELL_REST;
			end
		end else begin
			for (int k = 0; k < FIELDS; k++) begin
				if (sel[k]) begin
					fields_n[k] = in_data.packed_byte;
				end
			end
		end
	end

	// A cell is finished when nothing is pending or the data ends.
	assign emit = accept && !blocked && ((pend_n == '0) || in_data.end_of_data);

	// Position of the next cell.
	assign wrap     = (CLAMP_W'(chan_q) + CLAMP_W'(1)) >= chans;
	assign chan_adv = wrap ? '0 : chan_q + CHAN_W'(1);
	assign row_adv  = wrap ? row_q + ROW_W'(1) : row_q;
	assign done_n   = row_adv >= rows;

	// Finished cell toward the queue.
	always_comb begin
		cell_push.push                  = emit;
		cell_push.data.row_index        = row_q[ROW_OUT_W-1:0];
		cell_push.data.channel_index    = CHAN_OUT_W'(chan_q);
		cell_push.data.note_value       = fields_n[0];
		cell_push.data.instrument_value = fields_n[1];
		cell_push.data.volume_value     = fields_n[2];
		cell_push.data.effect_value     = fields_n[3];
		cell_push.data.param_value      = fields_n[4];
		cell_push.data.last_cell        = in_data.end_of_data || done_n;
	end

	// Cell assembly state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			chan_q    <= '0;
			row_q     <= '0;
			done_q    <= 1'b0;
		end else if (accept) begin
			if (in_data.end_of_data) begin
				pending_q <= '0;
				chan_q    <= '0;
				row_q     <= '0;
				done_q    <= 1'b0;
			end else if (blocked) begin
				done_q <= 1'b1;
			end else if (emit) begin
				pending_q <= '0;
				chan_q    <= chan_adv;
				row_q     <= row_adv;
				done_q    <= done_n;
			end else begin
				pending_q <= pend_n;
			end
		end
	end

	// Field bytes of the cell in progress.
	always_ff @(posedge clk) begin
		if (accept && !blocked) begin
			cell_q <= fields_n;
		end
	end

`ifndef SYNTHESIS
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_data.end_of_data |=> pending_q == '0 && chan_q == '0 && row_q == '0)
		else $error("pattern state not cleared after end of data");
	a_no_emit_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		blocked |-> !cell_push.push)
		else $error("cell emitted past the last row");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cell_push.push |-> !q_full)
		else $error("cell pushed into a full queue");
`endif

endmodule

>>> rtl/tpu_queue.sv
module tpu_queue import tpu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_push_t cell_push,
	output logic       full,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_data
);

	out_item_t          entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_q;
	logic [QPTR_W-1:0]  rd_q;
	logic [QCNT_W-1:0]  count_q;
	logic               pop;

	assign full      = count_q == QCNT_W'(QUEUE_DEPTH);
	assign out_valid = count_q != '0;
	assign out_data  = entry_q[rd_q];
	assign pop       = out_valid && out_ready;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (cell_push.push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (cell_push.push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !cell_push.push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (cell_push.push) begin
			entry_q[wr_q] <= cell_push.data;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue fill level out of range");
	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !cell_push.push |=> count_q == $past(count_q) - QCNT_W'(1))
		else $error("queue fill level not reduced by a pop");
`endif

endmodule

>>> bench/unpacked_cell_checker.sv
`timescale 1ns / 1ps

// Watches both streams of the pattern unpacker and the register port. It keeps
// its own copy of the unpacking state, works out the cell that each accepted
// byte request finishes, and compares every accepted cell with the oldest one
// still owed.
module unpacked_cell_checker import tpu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  in_item_t    in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  out_item_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int unsigned cells_waiting,
	output int unsigned mismatch_count
);

	localparam int unsigned CHANNEL_LIMIT = 32;
	localparam int unsigned ROW_LIMIT     = 256;
	localparam logic [CC_W-1:0]  CHANNELS_AFTER_RESET = 6'd2;
	localparam logic [ROW_W-1:0] ROWS_AFTER_RESET     = 9'd64;
	localparam int unsigned REPORT_LIMIT  = 10;

	// Register copies and the unpacking state.
	logic [CC_W-1:0]               channels_set;
	logic [ROW_W-1:0]              rows_set;
	logic [FIELDS-1:0]             fields_owed;
	logic [FIELDS-1:0][BYTE_W-1:0] cell_bytes;
	int unsigned                   chan_pos;
	int unsigned                   row_pos;
	logic                          pattern_over;
	out_item_t                     cells_due [$];
	int unsigned                   mismatch_total;

	// Back to row 0, channel 0 with no cell open.
	task automatic restart_pattern();
		fields_owed  = '0;
		cell_bytes   = '0;
		chan_pos     = 0;
		row_pos      = 0;
		pattern_over = 1'b0;
	endtask

	// Feeds one byte into the unpacking state and queues the cell it finishes, if any.
	task automatic unpack_byte(input in_item_t req);
		int unsigned rows_lim;
		int unsigned chans_lim;
		logic        taken;
		logic [7:0]  b;
		out_item_t   done_cell;
		b = req.packed_byte;
		rows_lim = (rows_set > ROW_LIMIT) ? ROW_LIMIT : rows_set;
		chans_lim = (channels_set < MIN_CHANNELS) ? MIN_CHANNELS : channels_set;
		if (chans_lim > CHANNEL_LIMIT)
			chans_lim = CHANNEL_LIMIT;

		// Past the last row everything is dropped until the data ends.
		if (pattern_over || row_pos >= rows_lim) begin
			pattern_over = 1'b1;
			if (req.end_of_data)
				restart_pattern();
			return;
		end

		if (fields_owed == '0) begin
			cell_bytes = '0;
			if (b[MASK_FLAG_BIT]) begin
				fields_owed = b[FIELDS-1:0];
			end else begin
				cell_bytes[0] = b;
				fields_owed = FULL_CELL_REST;
			end
		end else begin
			// The byte fills the lowest field still owed.
			taken = 1'b0;
			for (int k = 0; k < FIELDS; k++) begin
				if (!taken && fields_owed[k]) begin
					cell_bytes[k] = b;
					fields_owed[k] = 1'b0;
					taken = 1'b1;
				end
			end
		end

		if (fields_owed != '0 && !req.end_of_data)
			return;

		done_cell.row_index        = row_pos[ROW_OUT_W-1:0];
		done_cell.channel_index    = chan_pos[CHAN_OUT_W-1:0];
		done_cell.note_value       = cell_bytes[0];
		done_cell.instrument_value = cell_bytes[1];
		done_cell.volume_value     = cell_bytes[2];
		done_cell.effect_value     = cell_bytes[3];
		done_cell.param_value      = cell_bytes[4];

		// Advance to the next slot; the channel wraps into the next row.
		fields_owed = '0;
		cell_bytes  = '0;
		if (chan_pos + 1 >= chans_lim) begin
			chan_pos = 0;
			row_pos  = row_pos + 1;
		end else begin
			chan_pos = chan_pos + 1;
		end
		if (row_pos >= rows_lim)
			pattern_over = 1'b1;
		done_cell.last_cell = req.end_of_data || pattern_over;
		cells_due.push_back(done_cell);

		if (req.end_of_data)
			restart_pattern();
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			if (mismatch_total < REPORT_LIMIT)
				$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			mismatch_total++;
		end
	endtask

	// Results are compared before the byte of the same edge is predicted, since a
	// cell passes through the result queue registers before it can leave.
	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t want;
		if (!arst_n) begin
			channels_set = CHANNELS_AFTER_RESET;
			rows_set     = ROWS_AFTER_RESET;
			restart_pattern();
			cells_due.delete();
			mismatch_total = 0;
			cells_waiting  <= 0;
			mismatch_count <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (cells_due.size() == 0) begin
					if (mismatch_total < REPORT_LIMIT)
						$display("%0t: unexpected cell at row %0d channel %0d", $time,
							out_data.row_index, out_data.channel_index);
					mismatch_total++;
				end else begin
					want = cells_due.pop_front();
					check_field("row_index", want.row_index, out_data.row_index);
					check_field("channel_index", 8'(want.channel_index),
						8'(out_data.channel_index));
					check_field("note_value", want.note_value, out_data.note_value);
					check_field("instrument_value", want.instrument_value,
						out_data.instrument_value);
					check_field("volume_value", want.volume_value, out_data.volume_value);
					check_field("effect_value", want.effect_value, out_data.effect_value);
					check_field("param_value", want.param_value, out_data.param_value);
					check_field("last_cell", 8'(want.last_cell), 8'(out_data.last_cell));
				end
			end

			// Register writes land on the access cycle.
			if (psel && penable && pwrite && pready) begin
				case (paddr[2])
					REG_CHANNEL_COUNT: channels_set = pwdata[CC_W-1:0];
					REG_ROW_COUNT:     rows_set = pwdata[ROW_W-1:0];
					default:           ;
				endcase
			end

			if (in_valid && in_ready)
				unpack_byte(in_data);

			cells_waiting  <= cells_due.size();
			mismatch_count <= mismatch_total;
		end
	end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
	import tpu_pkg::*;

	localparam int CLK_PERIOD        = 12;
	localparam int RESET_CYCLES      = 6;
	localparam int SETTLE_CYCLES     = 8;
	localparam int HOLD_CYCLES       = 400;
	localparam int FIXED_PHASES      = 6;
	localparam int RANDOM_PHASES     = 6;
	localparam int PRESSURE_PHASE    = 5;
	localparam int DIRECTED_COUNT    = 25;
	localparam longint RUN_LIMIT_NS  = 64'd10_000_000;

	// Directed bytes, end_of_data in bit 8: full cells at the byte extremes, an
	// empty mask, a mask with the ignored bits set, a sparse mask, data ending
	// inside a cell, on a mask header and on the note of a full cell.
	localparam logic [0:DIRECTED_COUNT-1][8:0] DIRECTED_BYTES = {
		9'h07F, 9'h0FF, 9'h000, 9'h0AA, 9'h055,
		9'h000, 9'h001, 9'h002, 9'h003, 9'h004,
		9'h080,
		9'h0FF, 9'h011, 9'h022, 9'h033, 9'h044, 9'h055,
		9'h0E5, 9'h080, 9'h0FE, 9'h001,
		9'h09F, 9'h112,
		9'h19F,
		9'h140
	};

	typedef enum logic [1:0] {CELL_FULL, CELL_MASKED, CELL_SHORT, CELL_NOISE} cell_kind_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int unsigned cells_waiting;
	int unsigned mismatch_count;
	int unsigned bytes_offered;
	logic        steady_sender;
	logic        hold_request;

	tracker_pattern_unpacker DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	unpacked_cell_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.pready         (pready),
		.cells_waiting  (cells_waiting),
		.mismatch_count (mismatch_count)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Offers one byte request after an optional gap and returns at the edge that takes it.
	task automatic offer_byte(input logic [7:0] value, input logic eod);
		int unsigned gap;
		int unsigned pick;
		in_item_t    req;
		pick = $urandom_range(0, 99);
		if (steady_sender || pick < 60)
			gap = 0;
		else if (pick < 92)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(10, 40);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.packed_byte = value;
		req.end_of_data = eod;
		in_valid <= 1'b1;
		in_data  <= req;
		bytes_offered++;
		do @(posedge clk); while (!in_ready);
	endtask

	// Sends one cell; a closing cell carries end_of_data and is sometimes cut short.
	task automatic offer_cell(input cell_kind_t kind, input logic closes);
		logic [7:0]  burst [6];
		logic [7:0]  mask;
		int unsigned len;
		int unsigned cut;
		case (kind)
			CELL_FULL: begin
				burst[0] = 8'($urandom_range(0, 127));
				for (int k = 1; k < 5; k++)
					burst[k] = 8'($urandom_range(0, 255));
				len = 5;
			end
			CELL_NOISE: begin
				burst[0] = 8'($urandom_range(0, 255));
				len = 1;
			end
			default: begin
				if (kind == CELL_SHORT) begin
					mask = 8'h80 | 8'($urandom & 32'h60);
					if ($urandom_range(0, 99) >= 70)
						mask = mask | (8'h01 << $urandom_range(0, 4));
				end else begin
					mask = 8'h80 | 8'($urandom_range(0, 127));
				end
				burst[0] = mask;
				len = 1;
				for (int k = 0; k < FIELDS; k++) begin
					if (mask[k]) begin
						burst[len] = 8'($urandom_range(0, 255));
						len++;
					end
				end
			end
		endcase
		cut = len;
		if (closes && $urandom_range(0, 2) == 0)
			cut = $urandom_range(1, len);
		for (int k = 0; k < cut; k++)
			offer_byte(burst[k], closes && (k == cut - 1));
	endtask

	// Mostly well-formed cells with random content, some stray bytes and early ends.
	task automatic offer_stream(input int unsigned budget, input int unsigned close_one_in,
		input logic short_cells);
		int unsigned start;
		int unsigned pick;
		cell_kind_t  kind;
		logic        closes;
		start = bytes_offered;
		while (bytes_offered - start < budget) begin
			pick = $urandom_range(0, 99);
			if (short_cells)
				kind = (pick < 95) ? CELL_SHORT : CELL_NOISE;
			else if (pick < 40)
				kind = CELL_FULL;
			else if (pick < 88)
				kind = CELL_MASKED;
			else
				kind = CELL_NOISE;
			closes = (close_one_in != 0) && ($urandom_range(1, close_one_in) == 1);
			offer_cell(kind, closes);
		end
	endtask

	task automatic write_reg(input logic reg_sel, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Stops offering and waits for every owed cell, then lets a cell still being
	// assembled settle.
	task automatic wait_quiet();
		in_valid <= 1'b0;
		do @(posedge clk); while (cells_waiting != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Result side: random ready runs, short and long stalls, and one long hold-off.
	initial begin : result_sink
		int unsigned pick;
		int unsigned run;
		logic        hold_served;
		out_ready   = 1'b0;
		hold_served = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			pick = $urandom_range(0, 99);
			if (hold_request && !hold_served) begin
				hold_served = 1'b1;
				out_ready <= 1'b0;
				run = HOLD_CYCLES;
			end else if (pick < 10) begin
				out_ready <= 1'b1;
				run = $urandom_range(50, 150);
			end else if (pick < 55) begin
				out_ready <= 1'b1;
				run = $urandom_range(1, 20);
			end else if (pick < 92) begin
				out_ready <= 1'b0;
				run = $urandom_range(1, 3);
			end else begin
				out_ready <= 1'b0;
				run = $urandom_range(10, 60);
			end
			repeat (run) @(posedge clk);
		end
	end

	initial begin : stimulus
		int unsigned chans;
		int unsigned rows;
		int unsigned budget;
		int unsigned close_one_in;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_data       = '0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		bytes_offered = 0;
		steady_sender = 1'b0;
		hold_request  = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests under the reset register values.
		for (int k = 0; k < DIRECTED_COUNT; k++)
			offer_byte(DIRECTED_BYTES[k][7:0], DIRECTED_BYTES[k][8]);
		wait_quiet();

		// Each phase sets both registers while the unpacker is quiet, then streams bytes.
		// Phases that end without end_of_data leave a pattern open across the write.
		for (int ph = 0; ph < FIXED_PHASES + RANDOM_PHASES; ph++) begin
			steady_sender = 1'b0;
			case (ph)
				0: begin chans = 2;  rows = 1;   budget = 60;  close_one_in = 4;  end
				1: begin chans = 32; rows = 256; budget = 200; close_one_in = 60; end
				2: begin chans = 0;  rows = 0;   budget = 40;  close_one_in = 6;  end
				3: begin chans = 63; rows = 511; budget = 150; close_one_in = 40; end
				4: begin chans = 1;  rows = 3;   budget = 80;  close_one_in = 10; end
				PRESSURE_PHASE: begin
					chans = 2;
					rows = 256;
					budget = 700;
					close_one_in = 0;
					steady_sender = 1'b1;
				end
				default: begin
					chans = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) :
						$urandom_range(2, 8);
					rows = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 511) :
						$urandom_range(1, 12);
					budget = 130;
					close_one_in = 12;
					steady_sender = ($urandom_range(0, 2) == 0);
				end
			endcase
			write_reg(REG_CHANNEL_COUNT, ($urandom & ~32'h3F) | chans);
			write_reg(REG_ROW_COUNT, ($urandom & ~32'h1FF) | rows);
			if (ph == PRESSURE_PHASE)
				hold_request <= 1'b1;
			offer_stream(budget, close_one_in, ph == PRESSURE_PHASE);
			wait_quiet();
		end

		if (mismatch_count == 0 && cells_waiting == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> files.f
rtl/tpu_pkg.sv
rtl/tpu_front.sv
rtl/tpu_queue.sv
rtl/tracker_pattern_unpacker.sv
bench/unpacked_cell_checker.sv
bench/tb.sv
